/* sv/aub_pkg.sv */
// ----------------------------------------------------------------------------
// aub_pkg
// Shared types and constants for the H.264 access unit boundary detector.
// ----------------------------------------------------------------------------
package aub_pkg;

   // NAL unit type codes
   localparam logic [4:0] NAL_SLICE_LOW  = 5'd1;
   localparam logic [4:0] NAL_SLICE_HIGH = 5'd5;
   localparam logic [4:0] NAL_SEI        = 5'd6;
   localparam logic [4:0] NAL_SPS        = 5'd7;
   localparam logic [4:0] NAL_PPS        = 5'd8;
   localparam logic [4:0] NAL_AUD        = 5'd9;
   localparam logic [4:0] NAL_EXT_LOW    = 5'd14;
   localparam logic [4:0] NAL_EXT_HIGH   = 5'd18;

   // Slice type codes for intra pictures
   localparam logic [3:0] SLICE_I       = 4'd2;
   localparam logic [3:0] SLICE_I_ALL   = 4'd7;
   localparam logic [3:0] SLICE_SI      = 4'd4;
   localparam logic [3:0] SLICE_SI_ALL  = 4'd9;

   // Picture order count types that carry compared fields
   localparam logic [1:0] POC_TYPE_LSB   = 2'd0;
   localparam logic [1:0] POC_TYPE_DELTA = 2'd1;

   // One NAL unit summary
   typedef struct packed {
      logic [4:0]         nal_type;
      logic [1:0]         ref_idc;
      logic [15:0]        frame_index;
      logic [7:0]         pps_id;
      logic               bottom_field;
      logic [1:0]         poc_type;
      logic [15:0]        poc_lsb;
      logic signed [31:0] delta_poc_bottom;
      logic signed [31:0] delta_poc_first;
      logic signed [31:0] delta_poc_second;
      logic [6:0]         redundant_count;
      logic [3:0]         slice_kind;
   } req_item_type;

   // One result
   typedef struct packed {
      logic frame_boundary;
      logic primary_taken;
      logic keyframe;
      logic slice_added;
   } rsp_item_type;

   // Header of the held primary slice
   typedef struct packed {
      logic [15:0]        frame_index;
      logic [7:0]         pps_id;
      logic               bottom_field;
      logic [1:0]         ref_idc;
      logic [1:0]         poc_type;
      logic [15:0]        poc_lsb;
      logic signed [31:0] delta_bottom;
      logic signed [31:0] delta_first;
      logic signed [31:0] delta_second;
   } kept_hdr_type;

   // Decision for one NAL unit, passed from the decision logic
   typedef struct packed {
      rsp_item_type result;
      logic         have_next;
   } decision_type;

endpackage

/* sv/aub_req_if.sv */
// ----------------------------------------------------------------------------
// aub_req_if
// Valid/ready channel carrying NAL unit summaries.
// ----------------------------------------------------------------------------
interface aub_req_if import aub_pkg::*; ();

   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

/* sv/aub_rsp_if.sv */
// ----------------------------------------------------------------------------
// aub_rsp_if
// Valid/ready channel carrying boundary decisions.
// ----------------------------------------------------------------------------
interface aub_rsp_if import aub_pkg::*; ();

   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

/* sv/aub_decide.sv */
// ----------------------------------------------------------------------------
// aub_decide
// Compares one NAL unit summary against the held primary slice header and
// derives the boundary, primary and keyframe flags and the next held flag.
// ----------------------------------------------------------------------------
module aub_decide import aub_pkg::*; (
   input  req_item_type item,
   input  logic         have_primary,
   input  kept_hdr_type kept,
   output decision_type decision
);

   logic is_aud;
   logic is_ctrl;
   logic is_slice;
   logic is_primary;
   logic ref_differs;
   logic poc_lsb_differs;
   logic poc_delta_differs;
   logic differ;
   logic load;
   logic is_intra;

   // Classify the NAL unit
   always_comb begin
      is_aud   = (item.nal_type == NAL_AUD);
      is_ctrl  = (item.nal_type == NAL_SEI) || (item.nal_type == NAL_SPS) ||
                 (item.nal_type == NAL_PPS) ||
                 ((item.nal_type >= NAL_EXT_LOW) && (item.nal_type <= NAL_EXT_HIGH));
      is_slice = (item.nal_type >= NAL_SLICE_LOW) && (item.nal_type <= NAL_SLICE_HIGH);
      is_primary = is_slice && (item.redundant_count == 7'd0);
   end

   // Compare the slice header with the held one
   always_comb begin
      ref_differs = (item.ref_idc != kept.ref_idc) &&
                    ((item.ref_idc == 2'd0) || (kept.ref_idc == 2'd0));
      poc_lsb_differs = (item.poc_type == POC_TYPE_LSB) && (kept.poc_type == POC_TYPE_LSB) &&
                        ((item.poc_lsb != kept.poc_lsb) ||
                         (item.delta_poc_bottom != kept.delta_bottom));
      poc_delta_differs = (item.poc_type == POC_TYPE_DELTA) &&
                          (kept.poc_type == POC_TYPE_DELTA) &&
                          ((item.delta_poc_first != kept.delta_first) ||
                           (item.delta_poc_second != kept.delta_second));
      differ = (item.frame_index != kept.frame_index) || (item.pps_id != kept.pps_id) ||
               (item.bottom_field != kept.bottom_field) || ref_differs ||
               poc_lsb_differs || poc_delta_differs;
   end

   // Form the result and the next held flag
   always_comb begin
      load     = is_primary && (!have_primary || differ);
      is_intra = (item.slice_kind == SLICE_I) || (item.slice_kind == SLICE_I_ALL) ||
                 (item.slice_kind == SLICE_SI) || (item.slice_kind == SLICE_SI_ALL);
      decision.result.frame_boundary = is_aud || (have_primary && is_ctrl) ||
                                       (is_primary && have_primary && differ);
      decision.result.primary_taken  = load;
      decision.result.keyframe       = load && is_intra;
      decision.result.slice_added    = is_slice;
      decision.have_next = load || (have_primary && !is_aud && !is_ctrl);
   end

endmodule

/* sv/aub_state.sv */
// ----------------------------------------------------------------------------
// aub_state
// Holds the header of the first primary slice of the current picture and
// the flag that says one is held.
// ----------------------------------------------------------------------------
module aub_state import aub_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         load,
   input  logic         have_in,
   input  req_item_type item,
   output logic         have_primary,
   output kept_hdr_type kept
);

   logic         have_ff;
   kept_hdr_type kept_ff;
   kept_hdr_type kept_in;

   // Capture the header of a new primary slice
   always_comb begin
      kept_in.frame_index  = item.frame_index;
      kept_in.pps_id       = item.pps_id;
      kept_in.bottom_field = item.bottom_field;
      kept_in.ref_idc      = item.ref_idc;
      kept_in.poc_type     = item.poc_type;
      kept_in.poc_lsb      = item.poc_lsb;
      kept_in.delta_bottom = item.delta_poc_bottom;
      kept_in.delta_first  = item.delta_poc_first;
      kept_in.delta_second = item.delta_poc_second;
   end

   // Update the held flag once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (advance) begin
         have_ff <= have_in;
      end
   end

   // Load the header of a new primary slice
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
      end else if (advance && load) begin
         kept_ff <= kept_in;
      end
   end

   assign have_primary = have_ff;
   assign kept         = kept_ff;

endmodule

/* sv/h264_access_unit_boundary.sv */
// An accepted transaction waits in the input register, then its result in
// the result register. Throughput: one NAL unit per cycle unless the
// response channel stalls; the held header is updated at the same edge that
// registers the result, so the next unit compares against it.
// Reset clears both valid flags, the held-primary flag and the held header.
// ----------------------------------------------------------------------------
// h264_access_unit_boundary
// Detects H.264 access unit boundaries from pre-parsed NAL unit summaries.
// ----------------------------------------------------------------------------
module h264_access_unit_boundary import aub_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   aub_req_if.sink       req_chan,
   aub_rsp_if.source     rsp_chan
);

   logic         in_valid_ff;
   req_item_type in_data_ff;
   logic         out_valid_ff;
   rsp_item_type out_data_ff;
   logic         advance;
   logic         have_primary;
   kept_hdr_type kept;
   decision_type decision;

   // Advance the held transaction when the result register frees up
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.data;
      end
   end

   aub_decide u_decide (
      .item         (in_data_ff),
      .have_primary (have_primary),
      .kept         (kept),
      .decision     (decision)
   );

   aub_state u_state (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .load         (decision.result.primary_taken),
      .have_in      (decision.have_next),
      .item         (in_data_ff),
      .have_primary (have_primary),
      .kept         (kept)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= decision.result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   // Keyframe is only reported with a newly taken primary slice
   a_key_needs_primary: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_data_ff.keyframe || out_data_ff.primary_taken))
      else $error("keyframe without primary_taken");

   // A taken primary is always a slice
   a_primary_is_slice: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_data_ff.primary_taken || out_data_ff.slice_added))
      else $error("primary_taken on a non-slice NAL");

   // Taking a primary leaves one held
   a_primary_held: assert property (@(posedge clock) disable iff (reset)
      (advance && decision.result.primary_taken) |=> have_primary)
      else $error("primary not held after being taken");

   // A stalled input transaction stays in place
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("stalled input transaction lost");

endmodule
